### sv/assert_macros.svh
// assertion macros used by the rtl file stf_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/stf_pkg.sv
// package for the service time queue: sizes, codes and cell control type
`default_nettype none
package stf_pkg;

    localparam int DEPTH  = 16;
    localparam int ID_W   = 16;
    localparam int TIME_W = 16;
    localparam int QT_W   = 24;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = TIME_W + $clog2(DEPTH);
    localparam int CMP_W  = (SUM_W > QT_W) ? SUM_W : QT_W;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIND = 1'b1
    } t_state;

    // control for one cell, or for the whole row before the load decode
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage
`default_nettype wire

### sv/stf_cell.sv
// one queue cell: holds an entry, loads a new one or takes its neighbour's
`default_nettype none
module stf_cell import stf_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [ID_W-1:0]   i_ld_id,
    input  wire logic [TIME_W-1:0] i_ld_time,
    input  wire logic [ID_W-1:0]   i_nb_id,
    input  wire logic [TIME_W-1:0] i_nb_time,
    output logic      [ID_W-1:0]   o_id,
    output logic      [TIME_W-1:0] o_time
);

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_time;
    logic [ID_W-1:0]   n_id;
    logic [TIME_W-1:0] n_time;

    // shift towards the head, or take the item being enqueued
    always_comb begin
        n_id   = r_id;
        n_time = r_time;
        if (i_ctl.shift) begin
            n_id   = i_nb_id;
            n_time = i_nb_time;
        end else if (i_ctl.load) begin
            n_id   = i_ld_id;
            n_time = i_ld_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_time <= n_time;
    end

    assign o_id   = r_id;
    assign o_time = r_time;

endmodule
`default_nettype wire

### sv/stf_ctrl.sv
// queue controller: fill count, find walk over the head cell, result register
`default_nettype none
`include "assert_macros.svh"
module stf_ctrl import stf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [QT_W-1:0]   i_query_time,
    input  wire logic [ID_W-1:0]   i_head_id,
    input  wire logic [TIME_W-1:0] i_head_time,
    output t_cell_ctl              o_ctl,
    output logic      [CNT_W-1:0]  o_count,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [1:0]        o_status,
    output logic      [ID_W-1:0]   o_out_id,
    output logic      [TIME_W-1:0] o_out_time
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [QT_W-1:0]   r_qt, n_qt;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_time, n_time;
    logic              out_free;
    logic              acc;
    logic              enq_take;
    logic [SUM_W-1:0]  step_sum;
    t_op               op;
    t_cell_ctl         ctl;

    assign op       = t_op'(i_opcode);
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign acc      = i_valid && !o_stall;
    assign enq_take = acc && (op == OP_ENQUEUE) && (r_count != FULL_CNT);
    assign step_sum = r_sum + SUM_W'(i_head_time);

    // next state, row control and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_qt        = r_qt;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_id        = r_id;
        n_time      = r_time;
        ctl         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (op)
                        OP_ENQUEUE: begin
                            n_out_valid = 1'b1;
                            n_id        = '0;
                            n_time      = '0;
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                ctl.load = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_DEQUEUE, OP_PEEK: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_id     = '0;
                                n_time   = '0;
                            end else begin
                                n_status = ST_OK;
                                n_id     = i_head_id;
                                n_time   = i_head_time;
                                if (op == OP_DEQUEUE) begin
                                    ctl.shift = 1'b1;
                                    n_count   = r_count - 1'b1;
                                end
                            end
                        end
                        OP_FIND: begin
                            n_state = S_FIND;
                            n_sum   = '0;
                            n_qt    = i_query_time;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (r_count == '0) begin
                    // no entries left: queue was empty or the walk passed the total
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_EMPTY;
                        n_id        = '0;
                        n_time      = '0;
                        n_state     = S_IDLE;
                    end
                end else if (CMP_W'(step_sum) >= CMP_W'(r_qt)) begin
                    // head cell reaches the query time
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_OK;
                        n_id        = i_head_id;
                        n_time      = i_head_time;
                        n_state     = S_IDLE;
                    end
                end else begin
                    // drop the head and keep summing
                    ctl.shift = 1'b1;
                    n_count   = r_count - 1'b1;
                    n_sum     = step_sum;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_qt     <= n_qt;
        r_status <= n_status;
        r_id     <= n_id;
        r_time   <= n_time;
    end

    assign o_ctl      = ctl;
    assign o_count    = r_count;
    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_out_id   = r_id;
    assign o_out_time = r_time;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `ASSERT_ALWAYS(a_shift_nonempty, i_clk, i_rst_n, !ctl.shift || (r_count != '0))
    `ASSERT_ALWAYS(a_load_not_full, i_clk, i_rst_n, !ctl.load || (r_count != FULL_CNT))
    `ASSERT_NEXT(a_enq_count, i_clk, i_rst_n, enq_take, r_count == $past(r_count) + 1'b1)

endmodule
`default_nettype wire

### sv/service_time_fifo.sv
// enqueue, dequeue and peek give their result in the cycle after acceptance
// find walk: drops head entries until the running sum reaches the query time or none are left
// one non-find op per cycle unless the output stalls; no op is taken while a find walks
// the find walk inspects the head cell once per cycle while the cell row shifts forward
// reset is synchronous active low, clears count, state and result valid; cells are not cleared
`default_nettype none
module service_time_fifo import stf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [ID_W-1:0]   i_person_id,
    input  wire logic [TIME_W-1:0] i_service_time,
    input  wire logic [QT_W-1:0]   i_query_time,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [1:0]        o_status,
    output logic      [ID_W-1:0]   o_out_id,
    output logic      [TIME_W-1:0] o_out_time
);

    t_cell_ctl         row_ctl;
    logic [CNT_W-1:0]  count;
    logic [ID_W-1:0]   cell_id   [DEPTH+1];
    logic [TIME_W-1:0] cell_time [DEPTH+1];

    // nothing enters from beyond the tail cell
    assign cell_id[DEPTH]   = '0;
    assign cell_time[DEPTH] = '0;

    stf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_query_time (i_query_time),
        .i_head_id    (cell_id[0]),
        .i_head_time  (cell_time[0]),
        .o_ctl        (row_ctl),
        .o_count      (count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_id     (o_out_id),
        .o_out_time   (o_out_time)
    );

    // row of cells, head at position zero; an enqueue lands at the fill count
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl c_ctl;
        assign c_ctl.shift = row_ctl.shift;
        assign c_ctl.load  = row_ctl.load && (count == CNT_W'(g));
        stf_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (c_ctl),
            .i_ld_id   (i_person_id),
            .i_ld_time (i_service_time),
            .i_nb_id   (cell_id[g+1]),
            .i_nb_time (cell_time[g+1]),
            .o_id      (cell_id[g]),
            .o_time    (cell_time[g])
        );
    end

endmodule
`default_nettype wire

### test/tb_service_time_fifo.sv
// testbench for the service time queue: directed and random ops checked against a queue model
module tb_service_time_fifo;
    import stf_pkg::*;

    localparam int IDX_W        = $clog2(DEPTH);
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = DEPTH + 24;
    localparam int RANDOM_OPS   = 300;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] dur;
        logic [QT_W-1:0]   qt;
    } t_req;

    typedef struct packed {
        t_status           st;
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] dur;
    } t_rsp;

    // block ports
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_stall        = 1'b0;
    logic [1:0]        i_opcode       = '0;
    logic [ID_W-1:0]   i_person_id    = '0;
    logic [TIME_W-1:0] i_service_time = '0;
    logic [QT_W-1:0]   i_query_time   = '0;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [ID_W-1:0]   o_out_id;
    logic [TIME_W-1:0] o_out_time;

    // queue model state
    logic [ID_W-1:0]   q_pid [DEPTH];
    logic [TIME_W-1:0] q_dur [DEPTH];
    logic [IDX_W-1:0]  q_head  = '0;
    logic [IDX_W-1:0]  q_tail  = '0;
    logic [CNT_W-1:0]  q_count = '0;

    // stimulus and scoreboard
    t_req op_backlog[$];
    t_rsp want_results[$];
    t_req cur_req;
    logic took_item   = 1'b0;
    int   tx_pct      = 0;
    int   rx_pct      = 0;
    int   cycle_count = 0;
    int   err_count   = 0;
    int   n_op [4]    = '{0, 0, 0, 0};
    int   n_full      = 0;
    int   n_find_hit  = 0;
    int   n_find_miss = 0;

    service_time_fifo dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_person_id    (i_person_id),
        .i_service_time (i_service_time),
        .i_query_time   (i_query_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_time     (o_out_time)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // applies one op to the queue model and returns the result it should give
    function automatic t_rsp queue_outcome(t_req r);
        t_rsp             res;
        logic [IDX_W-1:0] p;
        int unsigned      run;
        int               k;
        logic             hit;
        res = '{ST_OK, '0, '0};
        case (r.op)
            OP_ENQUEUE: begin
                if (q_count >= DEPTH) begin
                    res.st = ST_FULL;
                end else begin
                    q_pid[q_tail] = r.pid;
                    q_dur[q_tail] = r.dur;
                    q_tail = ring_next(q_tail);
                    q_count = q_count + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (q_count == 0) begin
                    res.st = ST_EMPTY;
                end else begin
                    res.pid = q_pid[q_head];
                    res.dur = q_dur[q_head];
                    q_head = ring_next(q_head);
                    q_count = q_count - 1'b1;
                end
            end
            OP_PEEK: begin
                if (q_count == 0) begin
                    res.st = ST_EMPTY;
                end else begin
                    res.pid = q_pid[q_head];
                    res.dur = q_dur[q_head];
                end
            end
            default: begin
                // find: walk from the head until the running sum reaches the query time
                if (q_count == 0) begin
                    res.st = ST_EMPTY;
                end else begin
                    p = q_head;
                    run = 0;
                    hit = 1'b0;
                    for (k = 0; k < int'(q_count) && !hit; k++) begin
                        run += q_dur[p];
                        if (run >= r.qt) begin
                            hit = 1'b1;
                            res.pid = q_pid[p];
                            res.dur = q_dur[p];
                            q_head = p;
                            q_count = q_count - CNT_W'(k);
                        end else begin
                            p = ring_next(p);
                        end
                    end
                    // time beyond the total empties the queue
                    if (!hit) begin
                        q_head = '0;
                        q_tail = '0;
                        q_count = '0;
                        res.st = ST_EMPTY;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // driver: present the next item once the previous one has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || took_item) begin
                if (op_backlog.size() > 0 &&
                    (((cycle_count / 32) % 4 == 0) || $urandom_range(99) >= tx_pct)) begin
                    cur_req = op_backlog.pop_front();
                    i_valid        <= 1'b1;
                    i_opcode       <= cur_req.op;
                    i_person_id    <= cur_req.pid;
                    i_service_time <= cur_req.dur;
                    i_query_time   <= cur_req.qt;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ((cycle_count / 32) % 4 != 1) && ($urandom_range(99) < rx_pct);
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, want_results.size());
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n) begin
            t_rsp exp_rsp;
            t_req req;
            // compare a result with the oldest expectation
            if (o_valid && !i_stall) begin
                if (want_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d id %h time %h",
                             $time, o_status, o_out_id, o_out_time);
                    err_count++;
                end else begin
                    exp_rsp = want_results.pop_front();
                    if (o_status !== exp_rsp.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rsp.st, o_status);
                        err_count++;
                    end
                    if (o_out_id !== exp_rsp.pid) begin
                        $display("%0t: out_id expected %h actual %h",
                                 $time, exp_rsp.pid, o_out_id);
                        err_count++;
                    end
                    if (o_out_time !== exp_rsp.dur) begin
                        $display("%0t: out_time expected %h actual %h",
                                 $time, exp_rsp.dur, o_out_time);
                        err_count++;
                    end
                end
            end
            // accepted item: predict its result
            if (i_valid && !o_stall) begin
                req = '{t_op'(i_opcode), i_person_id, i_service_time, i_query_time};
                exp_rsp = queue_outcome(req);
                want_results.push_back(exp_rsp);
                n_op[i_opcode]++;
                if (exp_rsp.st == ST_FULL) n_full++;
                if (req.op == OP_FIND && exp_rsp.st == ST_OK) n_find_hit++;
                if (req.op == OP_FIND && exp_rsp.st == ST_EMPTY) n_find_miss++;
            end
            took_item <= i_valid && !o_stall;
        end
    end

    task automatic add_op(t_op op, int pid, int dur, int qt);
        op_backlog.push_back('{op, ID_W'(pid), TIME_W'(dur), QT_W'(qt)});
    endtask

    // random ops in chunks that lean towards filling, draining or neither
    task automatic add_random_ops(int n);
        int mode;
        int enq_th;
        int deq_th;
        int peek_th;
        int w;
        int dur;
        int qt;
        t_op op;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                mode = $urandom_range(2);
                case (mode)
                    0: begin enq_th = 75; deq_th = 83; peek_th = 90; end
                    1: begin enq_th = 25; deq_th = 55; peek_th = 70; end
                    default: begin enq_th = 45; deq_th = 65; peek_th = 80; end
                endcase
            end
            w = $urandom_range(99);
            if (w < enq_th) op = OP_ENQUEUE;
            else if (w < deq_th) op = OP_DEQUEUE;
            else if (w < peek_th) op = OP_PEEK;
            else op = OP_FIND;
            w = $urandom_range(99);
            if (w < 10) dur = 0;
            else if (w < 80) dur = $urandom_range(1, 15);
            else if (w < 90) dur = $urandom_range(16, 255);
            else dur = $urandom_range(65535);
            w = $urandom_range(99);
            if (w < 10) qt = 0;
            else if (w < 75) qt = $urandom_range(1, 120);
            else if (w < 90) qt = $urandom_range(2000);
            else qt = $urandom_range(16777215);
            add_op(op, $urandom_range(65535), dur, qt);
        end
    endtask

    // wait until every item has gone and every result has come back
    task automatic drain_all();
        while (op_backlog.size() > 0 || i_valid) @(posedge i_clk);
        while (want_results.size() > 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic run_phase(int tx, int rx);
        tx_pct = tx;
        rx_pct = rx;
        add_random_ops(RANDOM_OPS);
        drain_all();
    endtask

    // stimulus
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue cases
        add_op(OP_DEQUEUE, 16'hffff, 16'hffff, 24'hffffff);
        add_op(OP_PEEK, 16'hffff, 16'hffff, 24'hffffff);
        add_op(OP_FIND, 16'h1111, 16'h2222, 0);
        add_op(OP_FIND, 0, 0, 24'hffffff);
        // fill to the top, with extremes and zero durations near the head
        add_op(OP_ENQUEUE, 16'h0000, 16'hffff, 24'hffffff);
        add_op(OP_ENQUEUE, 16'hffff, 16'h0000, 0);
        add_op(OP_ENQUEUE, 16'h1234, 16'h0000, 0);
        add_op(OP_ENQUEUE, 16'h5678, 16'h0005, 0);
        for (int i = 4; i < DEPTH; i++) add_op(OP_ENQUEUE, 16'ha000 + i, (i % 3) ? i : 0, 0);
        // refused when full
        add_op(OP_ENQUEUE, 16'hffff, 16'hffff, 0);
        add_op(OP_PEEK, 0, 0, 0);
        // query time zero reports the head
        add_op(OP_FIND, 0, 0, 0);
        // skips the zero-duration entries after the big one
        add_op(OP_FIND, 0, 0, 24'h010000);
        // beyond the total empties the queue
        add_op(OP_FIND, 0, 0, 24'hffffff);
        drain_all();

        // random phases, each ending with the sender held off until all results are in
        run_phase(0, 0);
        run_phase(69, 0);
        run_phase(0, 69);
        run_phase(31, 31);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        // every accepted item must have produced its result
        if (want_results.size() != 0 || op_backlog.size() != 0) begin
            $display("%0t: results outstanding expected 0 actual %0d, items unsent %0d",
                     $time, want_results.size(), op_backlog.size());
            err_count++;
        end
        $display("ops: %0d enqueue (%0d refused full), %0d dequeue, %0d peek, %0d find",
                 n_op[OP_ENQUEUE], n_full, n_op[OP_DEQUEUE], n_op[OP_PEEK], n_op[OP_FIND]);
        $display("finds: %0d hit an entry, %0d found the queue empty or ran past the total",
                 n_find_hit, n_find_miss);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/stf_pkg.sv
sv/stf_cell.sv
sv/stf_ctrl.sv
sv/service_time_fifo.sv
test/tb_service_time_fifo.sv
